// ===== sv/dcc_pkg.sv =====
// Shared types and constants for the DMA channel controller.
package dcc_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_BEAT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [5:0] REG_CSR    = 6'h00;
  localparam logic [5:0] REG_CER    = 6'h01;
  localparam logic [5:0] REG_OCR    = 6'h05;
  localparam logic [5:0] REG_CCR    = 6'h07;
  localparam logic [5:0] REG_MTC_HI = 6'h0A;
  localparam logic [5:0] REG_MTC_LO = 6'h0B;
  localparam logic [5:0] REG_MAR_B3 = 6'h0C;
  localparam logic [5:0] REG_MAR_B2 = 6'h0D;
  localparam logic [5:0] REG_MAR_B1 = 6'h0E;
  localparam logic [5:0] REG_MAR_B0 = 6'h0F;

  localparam logic [7:0] CSR_COC      = 8'h80;
  localparam logic [7:0] CSR_ERR      = 8'h10;
  localparam logic [7:0] CSR_ACT      = 8'h08;
  localparam logic [7:0] CER_DEV_ERR  = 8'h0A;
  localparam logic [16:0] FULL_COUNT  = 17'h10000;

  localparam logic CFG_ATTACHED = 1'b0;
  localparam logic CFG_MEMORY   = 1'b1;

  typedef struct packed {
    logic [7:0]  csr;
    logic [7:0]  cer;
    logic [7:0]  ocr;
    logic [7:0]  ccr;
    logic [15:0] mtc;
    logic [31:0] mar;
  } chan_regs_t;

  typedef struct packed {
    logic       chan_we;
    logic [1:0] chan_idx;
    chan_regs_t chan_val;
    logic       gen_we;
    logic [7:0] gen_addr;
    logic [7:0] gen_data;
  } reg_upd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [7:0]  mem_data;
    logic [31:0] next_addr;
    logic        busy_res;
    logic        to_device;
    logic        done_res;
    logic        done_ok;
    logic [1:0]  done_channel;
  } result_t;

endpackage

// ===== sv/dcc_regs.sv =====
// Register storage: per-channel control registers and the general byte memory.
module dcc_regs #(
  parameter int CHANNELS       = 4,
  parameter int CHANNEL_STRIDE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          acc_addr,
  input  logic [1:0]          rd_ch,
  input  logic [1:0]          run_ch,
  input  dcc_pkg::reg_upd_t   upd,
  output dcc_pkg::chan_regs_t chan_rd,
  output dcc_pkg::chan_regs_t run_rd,
  output logic [7:0]          gen_rd
);
  import dcc_pkg::*;

  localparam int MEM_DEPTH = CHANNELS * CHANNEL_STRIDE;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CIW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  chan_regs_t chan_r [CHANNELS];
  logic [7:0] mem [MEM_DEPTH];
  logic       vld_r [MEM_DEPTH];
  logic [7:0] mem_q_r;
  logic       rd_vld_r;
  logic       fwd_r;
  logic [7:0] fwd_data_r;
  logic       fwd_hit;

  assign fwd_hit = upd.gen_we && (upd.gen_addr == acc_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) chan_r[i] <= '0;
    end else if (upd.chan_we) begin
      chan_r[upd.chan_idx[CIW-1:0]] <= upd.chan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEM_DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (upd.gen_we) begin
      vld_r[upd.gen_addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.gen_we) mem[upd.gen_addr[AW-1:0]] <= upd.gen_data;
  end

  // read at accept; a write retiring on the same edge is forwarded
  always_ff @(posedge clk) begin
    if (acc) begin
      mem_q_r    <= mem[acc_addr[AW-1:0]];
      rd_vld_r   <= vld_r[acc_addr[AW-1:0]] || fwd_hit;
      fwd_r      <= fwd_hit;
      fwd_data_r <= upd.gen_data;
    end
  end

  assign gen_rd  = !rd_vld_r ? 8'h00 : (fwd_r ? fwd_data_r : mem_q_r);
  assign chan_rd = chan_r[rd_ch[CIW-1:0]];
  assign run_rd  = chan_r[run_ch[CIW-1:0]];

endmodule

// ===== sv/dcc_core.sv =====
// Command decode, transfer engine state and register update logic.
module dcc_core #(
  parameter int CHANNELS       = 4,
  parameter int CHANNEL_STRIDE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [1:0]          s1_cmd,
  input  logic [7:0]          s1_off,
  input  logic [7:0]          s1_wdata,
  input  logic                s1_ok,
  input  logic [7:0]          s1_bdata,
  input  logic [3:0]          attached,
  input  logic                mem_on,
  input  dcc_pkg::chan_regs_t chan_rd,
  input  dcc_pkg::chan_regs_t run_rd,
  input  logic [7:0]          gen_rd,
  output logic [1:0]          rd_ch,
  output logic [1:0]          run_ch,
  output dcc_pkg::reg_upd_t   upd,
  output dcc_pkg::result_t    res
);
  import dcc_pkg::*;

  logic        running_r, running_nxt;
  logic [1:0]  run_ch_r, run_ch_nxt;
  logic [31:0] work_addr_r, work_addr_nxt;
  logic [16:0] work_count_r, work_count_nxt;
  logic        to_dev_r, to_dev_nxt;

  logic [7:0]  ch_full;
  logic [5:0]  reg_sel;
  logic        in_range;
  logic        special;
  logic [7:0]  byte_rd;
  logic [31:0] addr_inc;
  logic [16:0] cnt_dec;
  logic [31:0] new_addr;
  logic [16:0] new_cnt;
  logic        fin;
  logic        fin_ok;
  chan_regs_t  cv;

  assign ch_full  = 8'(s1_off / CHANNEL_STRIDE);
  assign reg_sel  = 6'(s1_off % CHANNEL_STRIDE);
  assign in_range = ch_full < 8'(CHANNELS);
  assign rd_ch    = ch_full[1:0];
  assign run_ch   = run_ch_r;
  assign addr_inc = work_addr_r + 32'd1;
  assign cnt_dec  = work_count_r - 17'd1;

  always_comb begin
    special = 1'b1;
    case (reg_sel)
      REG_CSR:    byte_rd = chan_rd.csr;
      REG_CER:    byte_rd = chan_rd.cer;
      REG_OCR:    byte_rd = chan_rd.ocr;
      REG_CCR:    byte_rd = chan_rd.ccr;
      REG_MTC_HI: byte_rd = chan_rd.mtc[15:8];
      REG_MTC_LO: byte_rd = chan_rd.mtc[7:0];
      REG_MAR_B3: byte_rd = chan_rd.mar[31:24];
      REG_MAR_B2: byte_rd = chan_rd.mar[23:16];
      REG_MAR_B1: byte_rd = chan_rd.mar[15:8];
      REG_MAR_B0: byte_rd = chan_rd.mar[7:0];
      default: begin
        special = 1'b0;
        byte_rd = gen_rd;
      end
    endcase
  end

  always_comb begin
    res            = '0;
    upd            = '0;
    cv             = chan_rd;
    running_nxt    = running_r;
    run_ch_nxt     = run_ch_r;
    work_addr_nxt  = work_addr_r;
    work_count_nxt = work_count_r;
    to_dev_nxt     = to_dev_r;
    new_addr       = work_addr_r;
    new_cnt        = work_count_r;
    fin            = 1'b0;
    fin_ok         = 1'b0;

    case (cmd_t'(s1_cmd))
      CMD_READ: begin
        if (!running_r && in_range) res.read_data = byte_rd;
      end
      CMD_WRITE: begin
        if (!running_r && in_range) begin
          if (special) begin
            case (reg_sel)
              REG_CSR:    cv.csr = chan_rd.csr & ~s1_wdata;
              REG_CER:    cv.cer = s1_wdata;
              REG_OCR:    cv.ocr = s1_wdata;
              REG_CCR:    cv.ccr = s1_wdata;
              REG_MTC_HI: cv.mtc[15:8] = s1_wdata;
              REG_MTC_LO: cv.mtc[7:0] = s1_wdata;
              REG_MAR_B3: cv.mar[31:24] = s1_wdata;
              REG_MAR_B2: cv.mar[23:16] = s1_wdata;
              REG_MAR_B1: cv.mar[15:8] = s1_wdata;
              REG_MAR_B0: cv.mar[7:0] = s1_wdata;
              default: ;
            endcase
            upd.chan_we  = 1'b1;
            upd.chan_idx = rd_ch;
            upd.chan_val = cv;
            if (reg_sel == REG_CCR && s1_wdata[7] && attached[rd_ch] && mem_on) begin
              running_nxt    = 1'b1;
              run_ch_nxt     = rd_ch;
              work_addr_nxt  = chan_rd.mar;
              work_count_nxt = (chan_rd.mtc == 16'd0) ? FULL_COUNT : {1'b0, chan_rd.mtc};
              to_dev_nxt     = !chan_rd.ocr[7];
              res.next_addr  = chan_rd.mar;
              res.busy_res   = 1'b1;
              res.to_device  = !chan_rd.ocr[7];
            end
          end else begin
            upd.gen_we   = 1'b1;
            upd.gen_addr = s1_off;
            upd.gen_data = s1_wdata;
          end
        end
      end
      CMD_BEAT: begin
        if (running_r) begin
          if (s1_ok) begin
            new_addr = addr_inc;
            new_cnt  = cnt_dec;
            fin      = (cnt_dec == 17'd0);
            fin_ok   = 1'b1;
          end else begin
            fin = 1'b1;
          end
          res.mem_addr  = work_addr_r;
          res.to_device = to_dev_r;
          res.mem_write = s1_ok && !to_dev_r;
          res.mem_data  = (s1_ok && !to_dev_r) ? s1_bdata : 8'h00;
          res.next_addr = new_addr;
          res.busy_res  = !fin;
          work_addr_nxt  = new_addr;
          work_count_nxt = new_cnt;
          if (fin) begin
            running_nxt      = 1'b0;
            res.done_res     = 1'b1;
            res.done_ok      = fin_ok;
            res.done_channel = run_ch_r;
            cv               = run_rd;
            cv.mar           = new_addr;
            cv.mtc           = new_cnt[15:0];
            cv.csr           = (run_rd.csr | (fin_ok ? CSR_COC : CSR_ERR)) & ~CSR_ACT;
            cv.cer           = fin_ok ? run_rd.cer : CER_DEV_ERR;
            upd.chan_we      = 1'b1;
            upd.chan_idx     = run_ch_r;
            upd.chan_val     = cv;
          end
        end
      end
      default: ;
    endcase

    if (!advance) begin
      upd.chan_we = 1'b0;
      upd.gen_we  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      run_ch_r     <= 2'd0;
      work_addr_r  <= 32'd0;
      work_count_r <= 17'd0;
      to_dev_r     <= 1'b0;
    end else if (advance) begin
      running_r    <= running_nxt;
      run_ch_r     <= run_ch_nxt;
      work_addr_r  <= work_addr_nxt;
      work_count_r <= work_count_nxt;
      to_dev_r     <= to_dev_nxt;
    end
  end

endmodule

// ===== sv/dma_channel_controller.sv =====
// Top level of the four-channel DMA controller: handshakes, config port, stage registers.
//
//   channel  dir  handshake            carries
//   in_      in   in_valid/in_stall    register read/write or transfer beat
//   out_     out  out_valid/out_stall  one result per item
//   config   in   APB psel/penable     attached_mask @0x0, memory_attached @0x4
//
// One item per cycle while out_stall is low; each item passes the input register, then the result register.
// The byte memory is read on the accept edge; a write retiring on that edge is forwarded.
// Synchronous active-low reset clears control state, all channel registers and memory valid bits.
// A stalled result holds in the result register while the next item waits in the input stage.
module dma_channel_controller #(
  parameter int CHANNELS       = 4,
  parameter int CHANNEL_STRIDE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_reg_offset,
  input  logic [7:0]  in_write_data,
  input  logic        in_beat_ok,
  input  logic [7:0]  in_beat_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_mem_write,
  output logic [31:0] out_mem_addr,
  output logic [7:0]  out_mem_data,
  output logic [31:0] out_next_addr,
  output logic        out_busy_res,
  output logic        out_to_device,
  output logic        out_done_res,
  output logic        out_done_ok,
  output logic [1:0]  out_done_channel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcc_pkg::*;

  logic       s1_vld_r;
  logic [1:0] s1_cmd_r;
  logic [7:0] s1_off_r;
  logic [7:0] s1_wdata_r;
  logic       s1_ok_r;
  logic [7:0] s1_bdata_r;
  logic       out_vld_r, out_vld_nxt;
  result_t    res_r;
  result_t    res;
  logic [3:0] attached_r;
  logic       mem_on_r;
  logic       advance;
  logic       acc;
  logic       cfg_wr;
  logic [1:0] rd_ch;
  logic [1:0] run_ch;
  reg_upd_t   upd;
  chan_regs_t chan_rd;
  chan_regs_t run_rd;
  logic [7:0] gen_rd;

  assign advance     = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = s1_vld_r && !advance;
  assign acc         = in_valid && !in_stall;
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= acc || in_stall;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r   <= in_cmd;
      s1_off_r   <= in_reg_offset;
      s1_wdata_r <= in_write_data;
      s1_ok_r    <= in_beat_ok;
      s1_bdata_r <= in_beat_data;
    end
    if (advance) res_r <= res;
  end

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 4'd0;
      mem_on_r   <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_ATTACHED) attached_r <= pwdata[3:0];
      else mem_on_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == CFG_ATTACHED) ? {28'd0, attached_r} : {31'd0, mem_on_r};

  dcc_regs #(
    .CHANNELS       (CHANNELS),
    .CHANNEL_STRIDE (CHANNEL_STRIDE)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .acc_addr (in_reg_offset),
    .rd_ch    (rd_ch),
    .run_ch   (run_ch),
    .upd      (upd),
    .chan_rd  (chan_rd),
    .run_rd   (run_rd),
    .gen_rd   (gen_rd)
  );

  dcc_core #(
    .CHANNELS       (CHANNELS),
    .CHANNEL_STRIDE (CHANNEL_STRIDE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .s1_cmd   (s1_cmd_r),
    .s1_off   (s1_off_r),
    .s1_wdata (s1_wdata_r),
    .s1_ok    (s1_ok_r),
    .s1_bdata (s1_bdata_r),
    .attached (attached_r),
    .mem_on   (mem_on_r),
    .chan_rd  (chan_rd),
    .run_rd   (run_rd),
    .gen_rd   (gen_rd),
    .rd_ch    (rd_ch),
    .run_ch   (run_ch),
    .upd      (upd),
    .res      (res)
  );

  assign out_valid        = out_vld_r;
  assign out_read_data    = res_r.read_data;
  assign out_mem_write    = res_r.mem_write;
  assign out_mem_addr     = res_r.mem_addr;
  assign out_mem_data     = res_r.mem_data;
  assign out_next_addr    = res_r.next_addr;
  assign out_busy_res     = res_r.busy_res;
  assign out_to_device    = res_r.to_device;
  assign out_done_res     = res_r.done_res;
  assign out_done_ok      = res_r.done_ok;
  assign out_done_channel = res_r.done_channel;

endmodule

// ===== sv/dcc_checker.sv =====
// Port-level checks for the DMA channel controller and their bind.
module dcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_mem_write,
  input logic       out_to_device,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic       out_done_ok,
  input logic [1:0] out_done_channel
);

  // a finished transfer never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done transfer still busy");

  // memory writes only on device-to-memory beats
  a_write_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_write |-> !out_to_device && !out_done_res || !out_to_device)
    else $error("memory write on a to-device beat");

  // done fields are zero unless a transfer ends
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> !out_done_ok && out_done_channel == 2'd0)
    else $error("done fields set without done");

  // a stalled result stays valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

endmodule

bind dma_channel_controller dcc_checker u_dcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_mem_write    (out_mem_write),
  .out_to_device    (out_to_device),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res),
  .out_done_ok      (out_done_ok),
  .out_done_channel (out_done_channel)
);

// ===== test/tb_dma_channel_controller.sv =====
// Self-checking testbench for the DMA channel controller: random register and transfer traffic.
module tb_dma_channel_controller;
  import dcc_pkg::*;

  localparam int LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 128;
  localparam logic [5:0] PEEK_REGS [6] = '{REG_CSR, REG_CER, REG_MTC_HI, REG_MTC_LO,
                                            REG_MAR_B3, REG_MAR_B0};

  class dma_register_model;
    localparam int NUM_CHAN = 4;
    localparam int STRIDE = 64;

    logic [7:0]  reg_bytes [256];
    bit          running;
    bit [1:0]    run_chan;
    bit [31:0]   work_addr;
    bit [16:0]   work_count;
    bit          run_to_dev;
    bit [3:0]    attached;
    bit          mem_attached;
    result_t     pending_results [$];
    int          errors;
    int          checked;
    int          runs_done;
    int          runs_aborted;

    function new();
      foreach (reg_bytes[i]) reg_bytes[i] = 8'h00;
      running = 1'b0;
      run_chan = 2'd0;
      work_addr = 32'd0;
      work_count = 17'd0;
      run_to_dev = 1'b0;
      attached = 4'h0;
      mem_attached = 1'b1;
      errors = 0;
      checked = 0;
      runs_done = 0;
      runs_aborted = 0;
    endfunction

    function void set_config(logic idx, logic [31:0] value);
      if (idx == CFG_ATTACHED) attached = value[3:0];
      else mem_attached = value[0];
    endfunction

    function int slot(int ch, int rg);
      return (ch * STRIDE + rg) % 256;
    endfunction

    function logic [7:0] byte_at(int ch, int rg);
      return reg_bytes[slot(ch, rg)];
    endfunction

    function void finish_run(bit ok);
      reg_bytes[slot(run_chan, REG_MAR_B3)] = work_addr[31:24];
      reg_bytes[slot(run_chan, REG_MAR_B2)] = work_addr[23:16];
      reg_bytes[slot(run_chan, REG_MAR_B1)] = work_addr[15:8];
      reg_bytes[slot(run_chan, REG_MAR_B0)] = work_addr[7:0];
      reg_bytes[slot(run_chan, REG_MTC_HI)] = work_count[15:8];
      reg_bytes[slot(run_chan, REG_MTC_LO)] = work_count[7:0];
      if (ok) begin
        reg_bytes[slot(run_chan, REG_CSR)] |= CSR_COC;
        runs_done++;
      end else begin
        reg_bytes[slot(run_chan, REG_CSR)] |= CSR_ERR;
        reg_bytes[slot(run_chan, REG_CER)] = CER_DEV_ERR;
        runs_aborted++;
      end
      reg_bytes[slot(run_chan, REG_CSR)] &= ~CSR_ACT;
      running = 1'b0;
    endfunction

    // Expected result of one accepted item; updates the shadow state.
    function void note_item(logic [1:0] cmd, logic [7:0] off, logic [7:0] wd, logic ok,
                            logic [7:0] bd);
      result_t r;
      int ch;
      int rg;
      int a;
      logic [7:0] ocr;
      r = '0;
      ch = off / STRIDE;
      rg = off % STRIDE;
      a = slot(ch, rg);
      case (cmd)
        CMD_READ: begin
          if (!running && ch < NUM_CHAN) r.read_data = reg_bytes[a];
        end
        CMD_WRITE: begin
          if (!running && ch < NUM_CHAN) begin
            if (rg == REG_CSR) begin
              reg_bytes[a] = reg_bytes[a] & ~wd;
            end else begin
              reg_bytes[a] = wd;
              if (rg == REG_CCR && wd[7] && attached[ch] && mem_attached) begin
                work_addr = {byte_at(ch, REG_MAR_B3), byte_at(ch, REG_MAR_B2),
                             byte_at(ch, REG_MAR_B1), byte_at(ch, REG_MAR_B0)};
                work_count = {1'b0, byte_at(ch, REG_MTC_HI), byte_at(ch, REG_MTC_LO)};
                if (work_count == 17'd0) work_count = FULL_COUNT;
                ocr = byte_at(ch, REG_OCR);
                run_to_dev = !ocr[7];
                run_chan = ch[1:0];
                running = 1'b1;
                r.next_addr = work_addr;
                r.busy_res = 1'b1;
                r.to_device = run_to_dev;
              end
            end
          end
        end
        CMD_BEAT: begin
          if (running) begin
            r.mem_addr = work_addr;
            r.to_device = run_to_dev;
            if (ok) begin
              if (!run_to_dev) begin
                r.mem_write = 1'b1;
                r.mem_data = bd;
              end
              work_addr = work_addr + 32'd1;
              work_count = work_count - 17'd1;
              if (work_count == 17'd0) begin
                finish_run(1'b1);
                r.done_res = 1'b1;
                r.done_ok = 1'b1;
                r.done_channel = run_chan;
              end
            end else begin
              finish_run(1'b0);
              r.done_res = 1'b1;
              r.done_channel = run_chan;
            end
            r.next_addr = work_addr;
            r.busy_res = running;
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", checked, field, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("no transfer pending", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.read_data !== want.read_data)
          report("read_data", got.read_data, want.read_data);
        if (got.mem_write !== want.mem_write)
          report("mem_write", got.mem_write, want.mem_write);
        if (got.mem_addr !== want.mem_addr)
          report("mem_addr", got.mem_addr, want.mem_addr);
        if (got.mem_data !== want.mem_data)
          report("mem_data", got.mem_data, want.mem_data);
        if (got.next_addr !== want.next_addr)
          report("next_addr", got.next_addr, want.next_addr);
        if (got.busy_res !== want.busy_res)
          report("busy_res", got.busy_res, want.busy_res);
        if (got.to_device !== want.to_device)
          report("to_device", got.to_device, want.to_device);
        if (got.done_res !== want.done_res)
          report("done_res", got.done_res, want.done_res);
        if (got.done_ok !== want.done_ok)
          report("done_ok", got.done_ok, want.done_ok);
        if (got.done_channel !== want.done_channel)
          report("done_channel", got.done_channel, want.done_channel);
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_reg_offset;
  logic [7:0]  in_write_data;
  logic        in_beat_ok;
  logic [7:0]  in_beat_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic        out_mem_write;
  logic [31:0] out_mem_addr;
  logic [7:0]  out_mem_data;
  logic [31:0] out_next_addr;
  logic        out_busy_res;
  logic        out_to_device;
  logic        out_done_res;
  logic        out_done_ok;
  logic [1:0]  out_done_channel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dma_register_model shadow;
  result_t           seen;
  bit                idle_on;
  bit                hold_req;
  int                items_sent;
  int                cfg_writes;
  int                cycle_count;
  int                stall_left;

  dma_channel_controller u_dut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_read_data, out_mem_write, out_mem_addr, out_mem_data, out_next_addr,
              out_busy_res, out_to_device, out_done_res, out_done_ok, out_done_channel};
      shadow.check_result(seen);
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 80;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_item(cmd_t cmd, logic [7:0] off, logic [7:0] wd, logic ok,
                           logic [7:0] bd);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_reg_offset = off;
    in_write_data = wd;
    in_beat_ok = ok;
    in_beat_data = bd;
    do @(posedge clk); while (in_stall);
    shadow.note_item(cmd, off, wd, ok, bd);
    items_sent++;
  endtask

  task automatic reg_write(logic [1:0] ch, logic [5:0] rg, logic [7:0] data);
    send_item(CMD_WRITE, {ch, rg}, data, 1'($urandom), 8'($urandom));
  endtask

  task automatic reg_read(logic [1:0] ch, logic [5:0] rg);
    send_item(CMD_READ, {ch, rg}, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    shadow.set_config(idx, data);
    cfg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Program one channel, try to start it, then beat until it ends or is cut off.
  task automatic program_and_run();
    logic [1:0] ch;
    logic [7:0] ccr;
    logic [7:0] mtc_hi;
    logic [7:0] mtc_lo;
    bit         wrap;
    int         sel;
    int         k;
    int         beats;
    ch = 2'($urandom_range(0, 3));
    wrap = ($urandom_range(0, 7) == 0);
    for (k = 0; k < 4; k++) begin
      if (wrap)
        reg_write(ch, REG_MAR_B3 + 6'(k), (k == 3) ? 8'($urandom_range(248, 255)) : 8'hFF);
      else if ($urandom_range(0, 1) == 1)
        reg_write(ch, REG_MAR_B3 + 6'(k), 8'($urandom));
    end
    sel = $urandom_range(0, 15);
    mtc_hi = (sel == 1) ? 8'($urandom) : 8'h00;
    mtc_lo = (sel == 0) ? 8'h00 : (sel == 1) ? 8'($urandom) : 8'($urandom_range(1, 8));
    reg_write(ch, REG_MTC_HI, mtc_hi);
    reg_write(ch, REG_MTC_LO, mtc_lo);
    if ($urandom_range(0, 3) != 0) reg_write(ch, REG_OCR, 8'($urandom));
    if ($urandom_range(0, 3) == 0) reg_write(ch, REG_CSR, 8'($urandom));
    ccr = 8'($urandom);
    ccr[7] = ($urandom_range(0, 7) != 0);
    reg_write(ch, REG_CCR, ccr);
    beats = 0;
    while (beats < 14 && (shadow.running || beats == 0)) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_item(CMD_BEAT, 8'($urandom), 8'($urandom),
                  (beats < 12) && ($urandom_range(0, 15) != 0), 8'($urandom));
        beats++;
      end
    end
    repeat ($urandom_range(1, 3)) reg_read(ch, PEEK_REGS[$urandom_range(0, 5)]);
    if ($urandom_range(0, 2) == 0) reg_write(ch, REG_CSR, 8'($urandom));
  endtask

  initial begin
    int phase;
    int phase_start;
    bit paused;
    logic [3:0] att;
    logic mem;
    shadow = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_READ;
    in_reg_offset = 8'h00;
    in_write_data = 8'h00;
    in_beat_ok = 1'b0;
    in_beat_data = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    idle_on = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    cfg_writes = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: channel 2 has no device
    write_cfg(CFG_ATTACHED, 32'hB);
    write_cfg(CFG_MEMORY, 32'h1);
    // device-to-memory run of two bytes across the address wrap
    reg_write(2'd1, REG_MAR_B3, 8'hFF);
    reg_write(2'd1, REG_MAR_B2, 8'hFF);
    reg_write(2'd1, REG_MAR_B1, 8'hFF);
    reg_write(2'd1, REG_MAR_B0, 8'hFE);
    reg_write(2'd1, REG_MTC_LO, 8'h02);
    reg_write(2'd1, REG_OCR, 8'h80);
    reg_write(2'd1, REG_CCR, 8'h80);
    reg_read(2'd1, REG_CSR);
    reg_write(2'd0, REG_CCR, 8'hFF);
    send_item(CMD_BEAT, 8'h00, 8'h00, 1'b1, 8'hFF);
    send_item(CMD_BEAT, 8'hFF, 8'hFF, 1'b1, 8'h00);
    reg_read(2'd1, REG_CSR);
    reg_write(2'd1, REG_CSR, 8'hFF);
    reg_read(2'd1, REG_MAR_B0);
    send_item(CMD_BEAT, 8'h55, 8'hAA, 1'b1, 8'h5A);
    send_item(CMD_NONE, 8'hAA, 8'h55, 1'b0, 8'hA5);
    reg_write(2'd2, REG_CCR, 8'h80);
    // full count (MTC zero), memory to device, detached mid-run, then refused byte
    reg_write(2'd0, REG_CCR, 8'h80);
    send_item(CMD_BEAT, 8'h00, 8'h00, 1'b1, 8'h00);
    wait_results();
    write_cfg(CFG_ATTACHED, 32'h0);
    send_item(CMD_BEAT, 8'h00, 8'h00, 1'b0, 8'h00);
    reg_read(2'd0, REG_CER);
    reg_read(2'd0, REG_MTC_HI);
    reg_read(2'd0, REG_MTC_LO);
    send_item(CMD_WRITE, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    send_item(CMD_READ, 8'hFF, 8'h00, 1'b0, 8'h00);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_results();
      att = 4'($urandom);
      mem = ($urandom_range(0, 3) != 0);
      if (phase == 0 || phase == 2 || phase == PHASES - 1) att = 4'hF;
      if (phase == 1) att = 4'h0;
      if (phase == 2) mem = 1'b0;
      if (phase < 2 || phase >= PHASES - 2) mem = 1'b1;
      write_cfg(CFG_ATTACHED, {28'd0, att});
      write_cfg(CFG_MEMORY, {31'd0, mem});
      idle_on = (phase != 3) && (phase < PHASES - 2);
      if (phase == 3) hold_req = 1'b1;
      phase_start = items_sent;
      paused = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (phase == 4 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          wait_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) program_and_run();
        else send_noise();
      end
    end

    wait_results();
    repeat (5) @(posedge clk);
    $display("Checked %0d results from %0d items over %0d config writes",
             shadow.checked, items_sent, cfg_writes);
    $display("Transfers ended: %0d by count, %0d by device refusal",
             shadow.runs_done, shadow.runs_aborted);
    if (shadow.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
